// ----- hw/rtl/acal_pkg.sv -----
package acal_pkg;

    localparam int ADC_BITS     = 10;
    localparam int CAL_SHIFT    = 5;
    localparam int OUT_BITS     = ADC_BITS + 1;
    localparam int SUM_BITS     = ADC_BITS + CAL_SHIFT;
    localparam int OP_BITS      = 2;
    localparam int STATUS_BITS  = 3;
    localparam int ORIENT_BITS  = 2;
    localparam int NUM_ORIENT   = 4;
    localparam int CFG_IDX_BITS = 3;

    typedef logic [ADC_BITS-1:0]        adc_t;
    typedef logic signed [OUT_BITS-1:0] out_t;
    typedef logic [SUM_BITS-1:0]        sum_t;
    typedef logic [CAL_SHIFT-1:0]       count_t;
    typedef logic [OP_BITS-1:0]         op_code_t;
    typedef logic [STATUS_BITS-1:0]     status_t;
    typedef logic [ORIENT_BITS-1:0]     orient_t;
    typedef logic [CFG_IDX_BITS-1:0]    cfg_idx_t;

    localparam op_code_t OP_MEASURE  = op_code_t'(0);
    localparam op_code_t OP_NORMAL   = op_code_t'(1);
    localparam op_code_t OP_INVERTED = op_code_t'(2);

    localparam status_t ST_MEASURED     = status_t'(0);
    localparam status_t ST_SAMPLE_TAKEN = status_t'(1);
    localparam status_t ST_NORMAL_DONE  = status_t'(2);
    localparam status_t ST_INV_DONE     = status_t'(3);
    localparam status_t ST_NOT_INVERTED = status_t'(4);
    localparam status_t ST_IGNORED      = status_t'(5);

    localparam cfg_idx_t REG_ORIENTATION = cfg_idx_t'(0);
    localparam cfg_idx_t REG_MID_FORWARD = cfg_idx_t'(1);
    localparam cfg_idx_t REG_MID_VERT    = cfg_idx_t'(2);
    localparam cfg_idx_t REG_MID_UPSIDE  = cfg_idx_t'(3);
    localparam cfg_idx_t REG_MID_AFT     = cfg_idx_t'(4);

    typedef enum logic [1:0] {
        CAL_NONE     = 2'd0,
        CAL_NORMAL   = 2'd1,
        CAL_INVERTED = 2'd2
    } cal_kind_t;

    // negate flags per orientation: {roll, pitch, yaw}
    localparam logic [NUM_ORIENT-1:0][2:0] POL_NEG = {3'b110, 3'b101, 3'b011, 3'b000};

    localparam logic [NUM_ORIENT-1:0][ADC_BITS-1:0] DEF_MID_RESET = {
        ADC_BITS'(640), ADC_BITS'(640), ADC_BITS'(615), ADC_BITS'(640)
    };

    typedef struct packed {
        orient_t                            orientation;
        logic [NUM_ORIENT-1:0][ADC_BITS-1:0] def_mid;
    } cfg_t;

    typedef struct packed {
        logic     valid;
        op_code_t op;
        adc_t     raw_pitch;
        adc_t     raw_roll;
        adc_t     raw_yaw;
    } item_t;

endpackage

// ----- hw/rtl/acal_if.sv -----
interface acal_in_if;
    import acal_pkg::*;

    logic     valid;
    logic     ready;
    op_code_t op;
    adc_t     raw_pitch;
    adc_t     raw_roll;
    adc_t     raw_yaw;

    modport source (output valid, output op, output raw_pitch, output raw_roll,
                    output raw_yaw, input ready);
    modport sink   (input valid, input op, input raw_pitch, input raw_roll,
                    input raw_yaw, output ready);
endinterface

interface acal_out_if;
    import acal_pkg::*;

    logic    valid;
    logic    ready;
    out_t    roll_out;
    out_t    pitch_out;
    out_t    yaw_out;
    adc_t    roll_zero;
    adc_t    pitch_zero;
    adc_t    yaw_zero;
    status_t status;

    modport source (output valid, output roll_out, output pitch_out, output yaw_out,
                    output roll_zero, output pitch_zero, output yaw_zero,
                    output status, input ready);
    modport sink   (input valid, input roll_out, input pitch_out, input yaw_out,
                    input roll_zero, input pitch_zero, input yaw_zero,
                    input status, output ready);
endinterface

// ----- hw/rtl/acal_cfg_regs.sv -----
module acal_cfg_regs (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  acal_pkg::cfg_idx_t     cfg_index,
    input  acal_pkg::adc_t         cfg_data,
    output acal_pkg::cfg_t         cfg
);
    import acal_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ORIENTATION: cfg_next.orientation = cfg_data[ORIENT_BITS-1:0];
                REG_MID_FORWARD: cfg_next.def_mid[0]  = cfg_data;
                REG_MID_VERT:    cfg_next.def_mid[1]  = cfg_data;
                REG_MID_UPSIDE:  cfg_next.def_mid[2]  = cfg_data;
                REG_MID_AFT:     cfg_next.def_mid[3]  = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.orientation <= '0;
            cfg_reg.def_mid     <= DEF_MID_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/acal_in_stage.sv -----
module acal_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    acal_in_if.sink         feed,
    input  logic            core_ready,
    output acal_pkg::item_t item
);
    import acal_pkg::*;

    logic     valid_reg;
    op_code_t op_reg;
    adc_t     pitch_reg;
    adc_t     roll_reg;
    adc_t     yaw_reg;
    logic     take;

    assign take       = !valid_reg || core_ready;
    assign feed.ready = take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= feed.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && feed.valid)
        begin
            op_reg    <= feed.op;
            pitch_reg <= feed.raw_pitch;
            roll_reg  <= feed.raw_roll;
            yaw_reg   <= feed.raw_yaw;
        end
    end

    assign item = {valid_reg, op_reg, pitch_reg, roll_reg, yaw_reg};

endmodule

// ----- hw/rtl/acal_core.sv -----
module acal_core (
    input  logic            clk,
    input  logic            rst_n,
    input  acal_pkg::cfg_t  cfg,
    input  acal_pkg::item_t item,
    output logic            core_ready,
    acal_out_if.source      result
);
    import acal_pkg::*;

    adc_t      zero_roll_reg, zero_pitch_reg, zero_yaw_reg, upright_yaw_reg;
    adc_t      zero_roll_next, zero_pitch_next, zero_yaw_next, upright_yaw_next;
    logic      normal_done_reg, inverted_done_reg;
    logic      normal_done_next, inverted_done_next;
    count_t    count_reg, count_next;
    cal_kind_t kind_reg, kind_next;
    sum_t      sum_roll_reg, sum_pitch_reg, sum_yaw_reg;
    sum_t      sum_roll_next, sum_pitch_next, sum_yaw_next;

    logic      out_valid_reg;
    out_t      roll_out_reg, pitch_out_reg, yaw_out_reg;
    status_t   status_reg;
    out_t      roll_v, pitch_v, yaw_v;
    status_t   status_v;

    logic      take;
    logic      keep_n, keep_i;
    count_t    cnt_n, cnt_i;
    sum_t      acc_roll, acc_pitch, acc_yaw_n, acc_yaw_i;
    out_t      d_roll, d_pitch, d_yaw;
    adc_t      avg_inv, dm;
    logic      yaw_neg, is_inv;
    out_t      half_diff, half, new_yaw;

    assign core_ready = !out_valid_reg || result.ready;
    assign take       = item.valid && core_ready;

    always_comb
    begin
        keep_n    = (kind_reg == CAL_NORMAL);
        keep_i    = (kind_reg == CAL_INVERTED);
        cnt_n     = keep_n ? count_reg : '0;
        cnt_i     = keep_i ? count_reg : '0;
        acc_roll  = (keep_n ? sum_roll_reg : '0) + SUM_BITS'(item.raw_roll);
        acc_pitch = (keep_n ? sum_pitch_reg : '0) + SUM_BITS'(item.raw_pitch);
        acc_yaw_n = (keep_n ? sum_yaw_reg : '0) + SUM_BITS'(item.raw_yaw);
        acc_yaw_i = (keep_i ? sum_yaw_reg : '0) + SUM_BITS'(item.raw_yaw);

        d_roll  = $signed({1'b0, item.raw_roll}) - $signed({1'b0, zero_roll_reg});
        d_pitch = $signed({1'b0, item.raw_pitch}) - $signed({1'b0, zero_pitch_reg});
        d_yaw   = $signed({1'b0, item.raw_yaw}) - $signed({1'b0, zero_yaw_reg});

        avg_inv   = acc_yaw_i[SUM_BITS-1:CAL_SHIFT];
        dm        = cfg.def_mid[cfg.orientation];
        yaw_neg   = POL_NEG[cfg.orientation][0];
        is_inv    = yaw_neg ? (avg_inv > dm) : (avg_inv < dm);
        half_diff = $signed({1'b0, upright_yaw_reg}) - $signed({1'b0, avg_inv});
        half      = half_diff >>> 1;
        new_yaw   = $signed({1'b0, upright_yaw_reg}) - half;
    end

    always_comb
    begin
        zero_roll_next     = zero_roll_reg;
        zero_pitch_next    = zero_pitch_reg;
        zero_yaw_next      = zero_yaw_reg;
        upright_yaw_next   = upright_yaw_reg;
        normal_done_next   = normal_done_reg;
        inverted_done_next = inverted_done_reg;
        count_next         = '0;
        kind_next          = CAL_NONE;
        sum_roll_next      = '0;
        sum_pitch_next     = '0;
        sum_yaw_next       = '0;
        roll_v             = '0;
        pitch_v            = '0;
        yaw_v              = '0;
        status_v           = ST_IGNORED;

        priority if (item.op == OP_MEASURE)
        begin
            roll_v   = POL_NEG[cfg.orientation][2] ? -d_roll : d_roll;
            pitch_v  = POL_NEG[cfg.orientation][1] ? -d_pitch : d_pitch;
            yaw_v    = yaw_neg ? -d_yaw : d_yaw;
            status_v = ST_MEASURED;
            if (!inverted_done_reg)
            begin
                zero_yaw_next = dm;
            end
        end
        else if (item.op == OP_NORMAL)
        begin
            if (&cnt_n)
            begin
                zero_roll_next     = acc_roll[SUM_BITS-1:CAL_SHIFT];
                zero_pitch_next    = acc_pitch[SUM_BITS-1:CAL_SHIFT];
                zero_yaw_next      = acc_yaw_n[SUM_BITS-1:CAL_SHIFT];
                upright_yaw_next   = acc_yaw_n[SUM_BITS-1:CAL_SHIFT];
                normal_done_next   = 1'b1;
                inverted_done_next = 1'b0;
                status_v           = ST_NORMAL_DONE;
            end
            else
            begin
                kind_next      = CAL_NORMAL;
                count_next     = cnt_n + count_t'(1);
                sum_roll_next  = acc_roll;
                sum_pitch_next = acc_pitch;
                sum_yaw_next   = acc_yaw_n;
                status_v       = ST_SAMPLE_TAKEN;
            end
        end
        else if (item.op == OP_INVERTED && normal_done_reg)
        begin
            if (&cnt_i)
            begin
                if (is_inv)
                begin
                    zero_yaw_next      = new_yaw[ADC_BITS-1:0];
                    inverted_done_next = 1'b1;
                    normal_done_next   = 1'b0;
                    status_v           = ST_INV_DONE;
                end
                else
                begin
                    status_v = ST_NOT_INVERTED;
                end
            end
            else
            begin
                kind_next    = CAL_INVERTED;
                count_next   = cnt_i + count_t'(1);
                sum_yaw_next = acc_yaw_i;
                status_v     = ST_SAMPLE_TAKEN;
            end
        end
        else
        begin
            status_v = ST_IGNORED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_roll_reg     <= '0;
            zero_pitch_reg    <= '0;
            zero_yaw_reg      <= '0;
            upright_yaw_reg   <= '0;
            normal_done_reg   <= 1'b0;
            inverted_done_reg <= 1'b0;
            count_reg         <= '0;
            kind_reg          <= CAL_NONE;
            sum_roll_reg      <= '0;
            sum_pitch_reg     <= '0;
            sum_yaw_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                zero_roll_reg     <= zero_roll_next;
                zero_pitch_reg    <= zero_pitch_next;
                zero_yaw_reg      <= zero_yaw_next;
                upright_yaw_reg   <= upright_yaw_next;
                normal_done_reg   <= normal_done_next;
                inverted_done_reg <= inverted_done_next;
                count_reg         <= count_next;
                kind_reg          <= kind_next;
                sum_roll_reg      <= sum_roll_next;
                sum_pitch_reg     <= sum_pitch_next;
                sum_yaw_reg       <= sum_yaw_next;
            end
            if (core_ready)
            begin
                out_valid_reg <= item.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            roll_out_reg  <= roll_v;
            pitch_out_reg <= pitch_v;
            yaw_out_reg   <= yaw_v;
            status_reg    <= status_v;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.roll_out   = roll_out_reg;
    assign result.pitch_out  = pitch_out_reg;
    assign result.yaw_out    = yaw_out_reg;
    assign result.roll_zero  = zero_roll_reg;
    assign result.pitch_zero = zero_pitch_reg;
    assign result.yaw_zero   = zero_yaw_reg;
    assign result.status     = status_reg;

endmodule

// ----- hw/rtl/accel_offset_calibration.sv -----
// Three-axis accelerometer conditioner with zero-offset calibration.
// feed:   one beat per sample set: op, raw_pitch, raw_roll, raw_yaw.
//         op measure gives corrected signed axes; op normal and op inverted each take
//         one calibration sample (inverted only after normal is done); 32 samples finish a calibration.
// result: one beat per feed beat: corrected axes (zero unless measuring),
//         the stored zeros after that beat, and a status code.
// cfg_*:  write port for orientation and the four default yaw mid values;
//         write only while no beat is in flight.
// Path: a feed beat accepted on feed lands in the input register, then goes
//         through the state update into the result register.
// Throughput: one beat per cycle while result.ready is high; the state update
//         is one short add, shift and compare between the input and result registers.
// Reset: zeros, sums, counts and flags clear; orientation is forward and the
//         default yaw mids are 640, 615, 640, 640.
// Stall: a held result keeps feed.ready high until the input register is
//         also full; then feed waits until result.ready frees the chain.
module accel_offset_calibration (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  acal_pkg::cfg_idx_t   cfg_index,
    input  acal_pkg::adc_t       cfg_data,
    acal_in_if.sink              feed,
    acal_out_if.source           result
);
    import acal_pkg::*;

    cfg_t  cfg;
    item_t item;
    logic  core_ready;

    acal_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    acal_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .feed       (feed),
        .core_ready (core_ready),
        .item       (item)
    );

    acal_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item       (item),
        .core_ready (core_ready),
        .result     (result)
    );

`ifndef SYNTH
    a_full_when_blocked : assert property (@(posedge clk) disable iff (!rst_n)
        !feed.ready |-> (result.valid && item.valid))
        else $error("feed blocked with a free stage");

    a_axes_zero_unless_measure : assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status != ST_MEASURED) |->
        (result.roll_out == '0 && result.pitch_out == '0 && result.yaw_out == '0))
        else $error("non-zero axes on a calibration result");

    a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.status <= ST_IGNORED))
        else $error("status code out of range");

    a_beat_advances : assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && core_ready) |=> result.valid)
        else $error("accepted beat lost before result register");
`endif

endmodule

// ----- test/tb_accel_offset_calibration.sv -----
`timescale 1ns / 1ps

module tb_accel_offset_calibration;
    import acal_pkg::*;

    localparam op_code_t OP_UNUSED      = op_code_t'(3);
    localparam int       CAL_COUNT      = 1 << CAL_SHIFT;
    localparam int       WATCHDOG_LIMIT = 2000;
    localparam int       PHASE_BEATS    = 180;
    localparam int       PRINT_LIMIT    = 100;

    // negate flags per orientation, {roll, pitch, yaw}
    localparam logic [2:0] AXIS_NEG [NUM_ORIENT] = '{3'b000, 3'b011, 3'b101, 3'b110};

    typedef struct {
        out_t    roll_out;
        out_t    pitch_out;
        out_t    yaw_out;
        adc_t    roll_zero;
        adc_t    pitch_zero;
        adc_t    yaw_zero;
        status_t status;
    } reading_t;

    logic     clk;
    logic     rst_n;
    logic     cfg_wr_en;
    cfg_idx_t cfg_index;
    adc_t     cfg_data;

    acal_in_if  feed_if();
    acal_out_if result_if();

    accel_offset_calibration u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .feed      (feed_if),
        .result    (result_if)
    );

    orient_t   mount;
    adc_t      mid_yaw [NUM_ORIENT];
    adc_t      zero_roll;
    adc_t      zero_pitch;
    adc_t      zero_yaw;
    adc_t      upright_yaw;
    bit        normal_done;
    bit        inverted_done;
    int        cal_count;
    cal_kind_t cal_running;
    int        sum_roll;
    int        sum_pitch;
    int        sum_yaw;

    reading_t expected_q [$];
    int       errors;
    int       useful_beats;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_calibration();
        cal_running = CAL_NONE;
        cal_count   = 0;
        sum_roll    = 0;
        sum_pitch   = 0;
        sum_yaw     = 0;
    endfunction

    function automatic void reset_conditioner();
        mount         = orient_t'(0);
        mid_yaw       = '{adc_t'(640), adc_t'(615), adc_t'(640), adc_t'(640)};
        zero_roll     = '0;
        zero_pitch    = '0;
        zero_yaw      = '0;
        upright_yaw   = '0;
        normal_done   = 1'b0;
        inverted_done = 1'b0;
        clear_calibration();
    endfunction

    function automatic reading_t condition_sample(op_code_t op, adc_t pitch, adc_t roll,
                                                  adc_t yaw);
        reading_t   r;
        logic [2:0] neg;
        int         diff;
        int         avg;
        bit         flipped;
        r   = '{default: 0};
        neg = AXIS_NEG[mount];
        if (op == OP_MEASURE)
        begin
            clear_calibration();
            diff        = int'(roll) - int'(zero_roll);
            r.roll_out  = out_t'(neg[2] ? -diff : diff);
            diff        = int'(pitch) - int'(zero_pitch);
            r.pitch_out = out_t'(neg[1] ? -diff : diff);
            diff        = int'(yaw) - int'(zero_yaw);
            r.yaw_out   = out_t'(neg[0] ? -diff : diff);
            if (!inverted_done)
                zero_yaw = mid_yaw[mount];
            r.status = ST_MEASURED;
        end
        else if (op == OP_NORMAL)
        begin
            if (cal_running != CAL_NORMAL)
            begin
                clear_calibration();
                cal_running = CAL_NORMAL;
            end
            sum_roll  += int'(roll);
            sum_pitch += int'(pitch);
            sum_yaw   += int'(yaw);
            cal_count++;
            if (cal_count >= CAL_COUNT)
            begin
                zero_roll     = adc_t'(sum_roll >> CAL_SHIFT);
                zero_pitch    = adc_t'(sum_pitch >> CAL_SHIFT);
                zero_yaw      = adc_t'(sum_yaw >> CAL_SHIFT);
                upright_yaw   = zero_yaw;
                normal_done   = 1'b1;
                inverted_done = 1'b0;
                clear_calibration();
                r.status = ST_NORMAL_DONE;
            end
            else
                r.status = ST_SAMPLE_TAKEN;
        end
        else if (op == OP_INVERTED && normal_done)
        begin
            if (cal_running != CAL_INVERTED)
            begin
                clear_calibration();
                cal_running = CAL_INVERTED;
            end
            sum_yaw += int'(yaw);
            cal_count++;
            if (cal_count >= CAL_COUNT)
            begin
                avg     = int'(adc_t'(sum_yaw >> CAL_SHIFT));
                flipped = neg[0] ? (avg > int'(mid_yaw[mount]))
                                 : (avg < int'(mid_yaw[mount]));
                clear_calibration();
                if (flipped)
                begin
                    diff          = int'(upright_yaw) - avg;
                    zero_yaw      = adc_t'(int'(upright_yaw) - (diff >>> 1));
                    inverted_done = 1'b1;
                    normal_done   = 1'b0;
                    r.status = ST_INV_DONE;
                end
                else
                    r.status = ST_NOT_INVERTED;
            end
            else
                r.status = ST_SAMPLE_TAKEN;
        end
        else
        begin
            clear_calibration();
            r.status = ST_IGNORED;
        end
        r.roll_zero  = zero_roll;
        r.pitch_zero = zero_pitch;
        r.yaw_zero   = zero_yaw;
        return r;
    endfunction

    function automatic adc_t jitter(adc_t centre, int spread);
        int offset;
        int v;
        offset = $urandom_range(0, 2 * spread);
        v      = int'(centre) + offset - spread;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return adc_t'(v);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (errors < PRINT_LIMIT)
            $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic compare_field(string what, int got, int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("beat with nothing outstanding", int'(result_if.status), -1);
            else
            begin
                want = expected_q.pop_front();
                compare_field("roll_out", int'(result_if.roll_out), int'(want.roll_out));
                compare_field("pitch_out", int'(result_if.pitch_out), int'(want.pitch_out));
                compare_field("yaw_out", int'(result_if.yaw_out), int'(want.yaw_out));
                compare_field("roll_zero", int'(result_if.roll_zero), int'(want.roll_zero));
                compare_field("pitch_zero", int'(result_if.pitch_zero),
                              int'(want.pitch_zero));
                compare_field("yaw_zero", int'(result_if.yaw_zero), int'(want.yaw_zero));
                compare_field("status", int'(result_if.status), int'(want.status));
            end
        end
    end

    always @(posedge clk)
        result_if.ready <= ($urandom_range(99) >= recv_stall_pct);

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (feed_if.valid && feed_if.ready)
                || (result_if.valid && result_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_beat(op_code_t op, adc_t pitch, adc_t roll, adc_t yaw);
        reading_t r;
        if ($urandom_range(99) < send_idle_pct)
        begin
            feed_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        feed_if.valid     <= 1'b1;
        feed_if.op        <= op;
        feed_if.raw_pitch <= pitch;
        feed_if.raw_roll  <= roll;
        feed_if.raw_yaw   <= yaw;
        do
            @(posedge clk);
        while (!feed_if.ready);
        r = condition_sample(op, pitch, roll, yaw);
        expected_q.push_back(r);
        if (r.status != ST_IGNORED)
            useful_beats++;
    endtask

    task automatic cal_run(op_code_t op, int beats, adc_t pitch, adc_t roll, adc_t yaw,
                           int spread);
        for (int i = 0; i < beats; i++)
            send_beat(op, jitter(pitch, spread), jitter(roll, spread), jitter(yaw, spread));
    endtask

    task automatic drain();
        feed_if.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, adc_t value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_ORIENTATION)
            mount = orient_t'(value);
        else
            mid_yaw[int'(idx) - 1] = value;
        @(posedge clk);
    endtask

    task automatic configure(orient_t o, adc_t fwd, adc_t vert, adc_t upside, adc_t aft);
        drain();
        write_reg(REG_ORIENTATION, adc_t'(o));
        write_reg(REG_MID_FORWARD, fwd);
        write_reg(REG_MID_VERT, vert);
        write_reg(REG_MID_UPSIDE, upside);
        write_reg(REG_MID_AFT, aft);
    endtask

    task automatic test_measure_extremes();
        send_beat(OP_MEASURE, 10'd0, 10'd0, 10'd0);
        send_beat(OP_MEASURE, 10'd1023, 10'd1023, 10'd1023);
        send_beat(OP_MEASURE, 10'h2AA, 10'h155, 10'h3FF);
        send_beat(OP_UNUSED, 10'd1023, 10'd0, 10'd1023);
        // inverted sample with no normal calibration behind it
        send_beat(OP_INVERTED, 10'd512, 10'd512, 10'd512);
    endtask

    task automatic test_normal_calibration();
        // interrupted run, then full runs at both ends of the range
        cal_run(OP_NORMAL, 10, 10'd100, 10'd200, 10'd300, 4);
        send_beat(OP_MEASURE, 10'd100, 10'd200, 10'd300);
        cal_run(OP_NORMAL, CAL_COUNT, 10'd1023, 10'd1023, 10'd1023, 0);
        send_beat(OP_MEASURE, 10'd0, 10'd0, 10'd0);
        cal_run(OP_NORMAL, CAL_COUNT, 10'd0, 10'd0, 10'd0, 0);
        send_beat(OP_MEASURE, 10'd1023, 10'd1023, 10'd1023);
    endtask

    task automatic test_inverted_calibration();
        cal_run(OP_NORMAL, CAL_COUNT, 10'd512, 10'd512, 10'd801, 3);
        cal_run(OP_INVERTED, 5, 10'd0, 10'd0, 10'd200, 5);
        send_beat(OP_UNUSED, 10'd0, 10'd0, 10'd0);
        cal_run(OP_INVERTED, CAL_COUNT, 10'd0, 10'd1023, 10'd200, 5);
        send_beat(OP_MEASURE, 10'd512, 10'd512, 10'd512);
        send_beat(OP_MEASURE, 10'd0, 10'd1023, 10'd0);
        send_beat(OP_INVERTED, 10'd0, 10'd0, 10'd200);
        // board still upright: the check must refuse
        cal_run(OP_NORMAL, CAL_COUNT, 10'd500, 10'd500, 10'd700, 2);
        cal_run(OP_INVERTED, CAL_COUNT, 10'd500, 10'd500, 10'd900, 2);
        send_beat(OP_MEASURE, 10'd500, 10'd500, 10'd900);
    endtask

    task automatic test_orientations();
        for (int o = 0; o < NUM_ORIENT; o++)
        begin
            if (o % 2 == 0)
                configure(orient_t'(o), 10'd1023, 10'd1023, 10'd1023, 10'd1023);
            else
                configure(orient_t'(o), 10'd0, 10'd0, 10'd0, 10'd0);
            send_beat(OP_MEASURE, adc_t'($urandom()), adc_t'($urandom()), adc_t'($urandom()));
            send_beat(OP_MEASURE, 10'd1023, 10'd0, 10'd511);
        end
        // vertical mount flips yaw, so an inverted board reads above the mid value
        configure(orient_t'(1), 10'd640, 10'd615, 10'd640, 10'd640);
        cal_run(OP_NORMAL, CAL_COUNT, 10'd400, 10'd600, 10'd300, 6);
        cal_run(OP_INVERTED, CAL_COUNT, 10'd400, 10'd600, 10'd900, 6);
        send_beat(OP_MEASURE, 10'd400, 10'd600, 10'd900);
    endtask

    task automatic random_traffic(int target);
        int   start;
        int   len;
        int   spread;
        adc_t centre_pitch;
        adc_t centre_roll;
        adc_t centre_yaw;
        start = useful_beats;
        while (useful_beats - start < target)
        begin
            len          = ($urandom_range(0, 5) == 0) ? $urandom_range(1, CAL_COUNT - 1)
                                                        : CAL_COUNT;
            spread       = $urandom_range(0, 20);
            centre_pitch = adc_t'($urandom());
            centre_roll  = adc_t'($urandom());
            centre_yaw   = adc_t'($urandom());
            case ($urandom_range(0, 9))
                0, 1, 2:
                    repeat ($urandom_range(1, 4))
                        send_beat(OP_MEASURE, adc_t'($urandom()), adc_t'($urandom()),
                                  adc_t'($urandom()));
                3, 4, 5:
                    cal_run(OP_NORMAL, len, centre_pitch, centre_roll, centre_yaw, spread);
                6, 7:
                begin
                    if (!normal_done)
                        cal_run(OP_NORMAL, CAL_COUNT, centre_pitch, centre_roll,
                                adc_t'($urandom()), spread);
                    cal_run(OP_INVERTED, len, centre_pitch, centre_roll, centre_yaw, spread);
                end
                default:
                    send_beat(op_code_t'($urandom()), adc_t'($urandom()), adc_t'($urandom()),
                              adc_t'($urandom()));
            endcase
        end
    endtask

    task automatic test_random_traffic();
        int send_pct [4] = '{0, 58, 0, 33};
        int stall_pct [4] = '{0, 0, 58, 33};
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                1:       configure(orient_t'(p), 10'd0, 10'd0, 10'd0, 10'd0);
                2:       configure(orient_t'(p), 10'd1023, 10'd1023, 10'd1023, 10'd1023);
                default: configure(orient_t'(p), adc_t'($urandom()), adc_t'($urandom()),
                                   adc_t'($urandom()), adc_t'($urandom()));
            endcase
            send_idle_pct  = send_pct[p];
            recv_stall_pct = stall_pct[p];
            random_traffic(PHASE_BEATS);
        end
    endtask

    initial
    begin
        errors         = 0;
        useful_beats   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        reset_conditioner();
        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_index         <= REG_ORIENTATION;
        cfg_data          <= '0;
        feed_if.valid     <= 1'b0;
        feed_if.op        <= OP_MEASURE;
        feed_if.raw_pitch <= '0;
        feed_if.raw_roll  <= '0;
        feed_if.raw_yaw   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 33;
        recv_stall_pct = 33;
        test_measure_extremes();
        test_normal_calibration();
        test_inverted_calibration();
        test_orientations();
        test_random_traffic();

        drain();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/acal_pkg.sv
hw/rtl/acal_if.sv
hw/rtl/acal_cfg_regs.sv
hw/rtl/acal_in_stage.sv
hw/rtl/acal_core.sv
hw/rtl/accel_offset_calibration.sv
test/tb_accel_offset_calibration.sv
